// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the sorted move list RTL.
// Both macros use the clock clk and the synchronous reset rst of the module
// in which they are placed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SQML_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sorted move list invariant violated");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define SQML_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted move list sequence check failed");

`endif

// ----- rtl/core/sqml_pkg.sv -----
`timescale 1ns / 1ps

package sqml_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 16;
  // Width of the occupancy counter, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width of the reported entry count field.
  localparam int ENTRY_COUNT_W = 5;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;

  // Declared from the top bit down, so that column sits in bits 7:0, row in
  // bits 15:8 and quality in bits 31:16, as on the stream data buses.
  typedef struct packed {
    logic signed [15:0] quality;
    logic [7:0]         row;
    logic [7:0]         column;
  } entry_t;

  // Contents of one cell of the chain.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } cell_state_t;

  // Command broadcast to every cell; at most one operation flag is set.
  typedef struct packed {
    logic   insert;
    logic   update;
    logic   pop;
    entry_t item;
  } cell_cmd_t;

endpackage

// ----- rtl/core/sorted_quality_move_list_top.sv -----
`timescale 1ns / 1ps
// Each result is registered and appears on the output in the cycle after acceptance.
// Throughput: one transaction per cycle unless the output stalls; each operation
// finishes in the cycle in which the chain shifts, rewrites or takes the new entry.
// Reset: synchronous and active high; it empties the list, clears the count and
// drops any pending result. Entry contents are not cleared, only their valid bits.

module sorted_quality_move_list_top
  import sqml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream: one operation per transaction.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // column [7:0], row [15:8], quality [31:16]
  input  logic [1:0]  s_axis_tuser,   // kind [1:0]
  // Output stream: one result per operation.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // head_column [7:0], head_row [15:8],
                                      // head_quality [31:16], entry_count [36:32],
                                      // refused [37], zero fill [39:38]
  output logic        m_axis_tuser    // head_valid
);

`include "assert_macros.svh"

  // The list is a chain of cells, cell 0 holding the head. Each operation is
  // broadcast to all cells, which decide locally what to hold next: on an insert
  // the cell at the insert position takes the new entry and the cells beyond it
  // take the contents of their neighbour nearer the head, on a pop every cell takes
  // the contents of its neighbour nearer the tail, and on an update each matching
  // cell rewrites its own score without any movement.

  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [1:0]        kind;
  cell_cmd_t         cmd;
  logic              refuse_now;

  cell_state_t       cells      [CAPACITY];
  cell_state_t       cells_next [CAPACITY];
  logic              found      [CAPACITY+1];
  logic [CAPACITY-1:0] valid_vec;

  // A single output register separates the two sides, so a new transaction is
  // taken whenever that register is empty or is being drained in this cycle.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser;
  assign full          = count == CNT_W'(CAPACITY);

  // Decode the operation into the command seen by every cell.
  always_comb begin
    cmd.insert  = 1'b0;
    cmd.update  = 1'b0;
    cmd.pop     = 1'b0;
    cmd.item    = s_axis_tdata;
    refuse_now  = 1'b0;
    count_next  = count;
    if (accept) begin
      unique case (kind)
        KIND_INSERT: begin
          if (full) begin
            refuse_now = 1'b1;
          end else begin
            cmd.insert = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        KIND_UPDATE: begin
          cmd.update = 1'b1;
        end
        KIND_POP: begin
          if (count != '0) begin
            cmd.pop    = 1'b1;
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
          // The spare code leaves the list alone and only reports the head.
        end
      endcase
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_state_t left_in;
    cell_state_t right_in;

    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_mid_left
      assign left_in = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid_right
      assign right_in = cells[i+1];
    end

    sqml_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left       (left_in),
      .right      (right_in),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .state      (cells[i]),
      .state_next (cells_next[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register: the head is taken from the value cell 0 is about to hold,
  // so the result describes the list after the operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tuser              <= cells_next[0].valid;
      m_axis_tdata[39:38]       <= 2'b00;
      m_axis_tdata[37]          <= refuse_now;
      m_axis_tdata[36:32]       <= ENTRY_COUNT_W'(count_next);
      if (cells_next[0].valid) begin
        m_axis_tdata[31:0]      <= cells_next[0].entry;
      end else begin
        m_axis_tdata[31:0]      <= '0;
      end
    end
  end

  // The count always equals the number of occupied cells.
  `SQML_ASSERT_ALWAYS(a_count_matches_cells, $countones(valid_vec) == 32'(count))
  // The count never exceeds the capacity.
  `SQML_ASSERT_ALWAYS(a_count_bounded, count <= CNT_W'(CAPACITY))
  // A pop on a non-empty list shortens it by exactly one entry.
  `SQML_ASSERT_NEXT(a_pop_shrinks, cmd.pop,
                    count == $past(count) - CNT_W'(1))
  // A refused insert leaves the list full and unchanged in length.
  `SQML_ASSERT_NEXT(a_refuse_keeps_full, refuse_now,
                    count == CNT_W'(CAPACITY) && m_axis_tdata[37])

endmodule

// ----- rtl/core/sqml_cell.sv -----
`timescale 1ns / 1ps

module sqml_cell
  import sqml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cell_cmd_t   cmd,
  input  cell_state_t left,       // contents of the cell nearer the head
  input  cell_state_t right,      // contents of the cell nearer the tail
  input  logic        found_in,   // insert position lies nearer the head
  output logic        found_out,
  output cell_state_t state,
  output cell_state_t state_next
);

  logic greater;
  logic hit;
  logic match;

  // The new item stops at the first cell that is empty or whose score is
  // not greater than the new one.
  assign greater   = state.entry.quality > cmd.item.quality;
  assign hit       = !state.valid || !greater;
  assign found_out = found_in || hit;
  assign match     = state.valid && (state.entry.column == cmd.item.column)
                     && (state.entry.row == cmd.item.row);

  always_comb begin
    state_next = state;
    if (cmd.insert) begin
      if (found_in) begin
        state_next = left;
      end else if (hit) begin
        state_next.valid = 1'b1;
        state_next.entry = cmd.item;
      end
    end else if (cmd.update) begin
      if (match) begin
        state_next.entry.quality = cmd.item.quality;
      end
    end else if (cmd.pop) begin
      state_next = right;
    end
  end

  // Only the valid bit is reset; the entry is meaningless while it is clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.valid <= 1'b0;
    end else begin
      state.valid <= state_next.valid;
    end
    state.entry <= state_next.entry;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sqml_pkg::*;

  // The package names the three real operations; the fourth code does nothing.
  localparam logic [1:0] KIND_NOP = 2'd3;

  // A quiet spell of this many cycles, with no transaction on either side, ends the run.
  localparam int WATCHDOG_LIMIT = 500;
  // Each result is registered when its transaction is accepted, so DRAIN_CYCLES is
  // enough to be sure that nothing stray follows the last result.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS = 75;

  // One result as the block reports it, in the order of its fields.
  typedef struct packed {
    logic               head_valid;
    logic [7:0]         head_column;
    logic [7:0]         head_row;
    logic signed [15:0] head_quality;
    logic [4:0]         entry_count;
    logic               refused;
  } list_report_t;

  localparam list_report_t NO_HEAD = '0;

  // One row of the directed table. A row with reps above one repeats its
  // operation with random content. Where typed is set, want is the result
  // that is expected; otherwise the result comes from the shadow list.
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         column;
    logic [7:0]         row;
    logic signed [15:0] quality;
    logic [4:0]         reps;
    logic               typed;
    list_report_t       want;
  } plan_row_t;

  localparam int PLAN_ROWS = 16;

  // Directed part: operations on the empty list, the extreme coordinates and
  // scores, a tie with the head, an update that breaks the order, an update
  // that matches nothing, the unused code, filling the list and an insert
  // that is refused because it is full.
  plan_row_t move_plan [PLAN_ROWS] = '{
    '{KIND_POP,    8'd0,   8'd0,   16'sd0,      5'd1,  1'b1, NO_HEAD},
    '{KIND_UPDATE, 8'd255, 8'd255, -16'sd1,     5'd1,  1'b1, NO_HEAD},
    '{KIND_NOP,    8'd0,   8'd0,   16'sd0,      5'd1,  1'b1, NO_HEAD},
    '{KIND_INSERT, 8'd255, 8'd255, 16'sh8000,   5'd1,  1'b1,
      '{1'b1, 8'd255, 8'd255, 16'sh8000, 5'd1, 1'b0}},
    '{KIND_INSERT, 8'd0,   8'd0,   16'sh7fff,   5'd1,  1'b1,
      '{1'b1, 8'd0, 8'd0, 16'sh7fff, 5'd2, 1'b0}},
    '{KIND_INSERT, 8'd1,   8'd2,   16'sh7fff,   5'd1,  1'b1,
      '{1'b1, 8'd1, 8'd2, 16'sh7fff, 5'd3, 1'b0}},
    '{KIND_INSERT, 8'd170, 8'd85,  16'sd0,      5'd1,  1'b0, NO_HEAD},
    '{KIND_INSERT, 8'd85,  8'd170, 16'sd0,      5'd1,  1'b0, NO_HEAD},
    '{KIND_UPDATE, 8'd1,   8'd2,   16'sh8000,   5'd1,  1'b1,
      '{1'b1, 8'd1, 8'd2, 16'sh8000, 5'd5, 1'b0}},
    '{KIND_INSERT, 8'd3,   8'd3,   -16'sd100,   5'd1,  1'b0, NO_HEAD},
    '{KIND_UPDATE, 8'd200, 8'd200, 16'sd5,      5'd1,  1'b0, NO_HEAD},
    '{KIND_NOP,    8'd0,   8'd0,   16'sd0,      5'd1,  1'b0, NO_HEAD},
    '{KIND_INSERT, 8'd0,   8'd0,   16'sd0,      5'd10, 1'b0, NO_HEAD},
    '{KIND_INSERT, 8'd255, 8'd0,   16'sh7fff,   5'd1,  1'b0, NO_HEAD},
    '{KIND_POP,    8'd0,   8'd0,   16'sd0,      5'd1,  1'b0, NO_HEAD},
    '{KIND_UPDATE, 8'd0,   8'd0,   16'sh8000,   5'd1,  1'b0, NO_HEAD}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_NOP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Shadow of the list: the entries in order and how many are held.
  entry_t       shadow_moves [CAPACITY];
  int           shadow_count = 0;
  // Results still owed by the block, oldest first.
  list_report_t pending_reports [$];
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  // While set, neither side inserts any pause between transactions.
  bit           calm = 1'b0;

  sorted_quality_move_list_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the shadow list and returns the report that the
  // block must give for it. An insert stops at the first entry whose score is
  // not greater, so it goes ahead of equal scores; an update leaves the order
  // as it is, even where the new score breaks it.
  function automatic list_report_t apply_move_op(logic [1:0] kind, entry_t move);
    list_report_t report;
    int           pos;
    report = '0;
    case (kind)
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          report.refused = 1'b1;
        end else begin
          pos = 0;
          while (pos < shadow_count &&
                 $signed(shadow_moves[pos].quality) > $signed(move.quality)) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_moves[i] = shadow_moves[i - 1];
          shadow_moves[pos] = move;
          shadow_count++;
        end
      end
      KIND_UPDATE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_moves[i].column == move.column && shadow_moves[i].row == move.row)
            shadow_moves[i].quality = move.quality;
        end
      end
      KIND_POP: begin
        if (shadow_count > 0) begin
          for (int i = 1; i < shadow_count; i++) shadow_moves[i - 1] = shadow_moves[i];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    if (shadow_count > 0) begin
      report.head_valid   = 1'b1;
      report.head_column  = shadow_moves[0].column;
      report.head_row     = shadow_moves[0].row;
      report.head_quality = shadow_moves[0].quality;
    end
    report.entry_count = shadow_count[4:0];
    return report;
  endfunction

  // Scores lean towards the extremes and towards a narrow band around zero,
  // so that ties with held entries are common.
  function automatic logic signed [15:0] draw_quality();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1:       return 16'($signed($urandom_range(0, 4)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // Coordinates come half of the time from a small pool, which makes
  // duplicate coordinates and multi-entry updates likely.
  function automatic logic [7:0] draw_coord();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  // Offers one operation after a random pause and waits for its handshake.
  // The expected report is worked out at the edge where the transaction is
  // accepted, so the shadow list always follows the block's own order.
  task automatic send_move_op(input logic [1:0] kind, input entry_t move,
                              input logic typed, input list_report_t want);
    int           gap;
    list_report_t predicted;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {move.quality, move.row, move.column};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_move_op(kind, move);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  initial begin : stimulus
    entry_t     move;
    logic [1:0] kind;
    int         insert_pct;
    int         pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (move_plan[r]) begin
      for (int n = 0; n < move_plan[r].reps; n++) begin
        move.column  = move_plan[r].column;
        move.row     = move_plan[r].row;
        move.quality = move_plan[r].quality;
        if (move_plan[r].reps > 1) begin
          move.column  = draw_coord();
          move.row     = draw_coord();
          move.quality = draw_quality();
        end
        send_move_op(move_plan[r].kind, move, move_plan[r].typed, move_plan[r].want);
      end
    end

    // Random part. Phases alternate between filling, draining and a balanced
    // mix, so that the list keeps running into both the full and the empty
    // case. Every fourth phase runs without pauses on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      calm = (phase % 4 == 3);
      case (phase % 3)
        0:       insert_pct = 70;
        1:       insert_pct = 25;
        default: insert_pct = 45;
      endcase
      // Once in the run the sender holds back until the block has answered
      // every transaction already accepted.
      if (phase == RANDOM_PHASES / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) kind = KIND_INSERT;
        else if (pick < insert_pct + 20) kind = KIND_UPDATE;
        else if (pick < 98) kind = KIND_POP;
        else kind = KIND_NOP;
        move.column  = draw_coord();
        move.row     = draw_coord();
        move.quality = draw_quality();
        // Most updates aim at an entry that is actually held.
        if (kind == KIND_UPDATE && shadow_count > 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, shadow_count - 1);
          move.column = shadow_moves[pick].column;
          move.row    = shadow_moves[pick].row;
        end
        send_move_op(kind, move, 1'b0, NO_HEAD);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** sorted_quality_move_list_top: PASSED **");
    end else begin
      $display("** sorted_quality_move_list_top: FAILED **");
    end
    $finish;
  end

  // Receiver: stalls for a random number of cycles before each result.
  initial begin : receiver
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Every result transaction is held against the oldest report still owed.
  always @(posedge clk) begin : report_check
    list_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with no operation outstanding: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tuser !== want.head_valid) begin
          $error("head_valid: expected %0d, got %0d", want.head_valid, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[7:0] !== want.head_column) begin
          $error("head_column: expected %0d, got %0d", want.head_column, m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[15:8] !== want.head_row) begin
          $error("head_row: expected %0d, got %0d", want.head_row, m_axis_tdata[15:8]);
          mismatch_count++;
        end
        if (m_axis_tdata[31:16] !== want.head_quality) begin
          $error("head_quality: expected %0d, got %0d", want.head_quality,
                 $signed(m_axis_tdata[31:16]));
          mismatch_count++;
        end
        if (m_axis_tdata[36:32] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 m_axis_tdata[36:32]);
          mismatch_count++;
        end
        if (m_axis_tdata[37] !== want.refused) begin
          $error("refused: expected %0d, got %0d", want.refused, m_axis_tdata[37]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: the longest quiet spell in a correct run is one sender pause
  // plus one receiver stall plus the latency, far below the limit.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** sorted_quality_move_list_top: FAILED **");
        $finish;
      end
    end
  end

endmodule
